FILE: src/pds_pkg.sv
`timescale 1ns / 1ps
package pds_pkg;

	// Number of time bases and search depth of the period count
	localparam int NBASE  = 4;
	localparam int NBITS  = 8;

	// Twice the base numerator P and the base denominator Q, base 0 rightmost
	localparam logic [NBASE-1:0][26:0] BASE_P2 = {27'd250, 27'd200000, 27'd1250000, 27'd80000000};
	localparam logic [NBASE-1:0][5:0]  BASE_Q  = {6'd13, 6'd41, 6'd1, 6'd1};

	localparam logic [7:0]  N_MIN     = 8'd2;
	localparam logic [7:0]  W_MIN     = 8'd1;
	localparam logic [6:0]  PCT       = 7'd100;
	localparam logic [12:0] PCT_RECIP = 13'd5242;  // 2^19/100, rounded down

	// Request travelling down the search chain
	typedef struct packed {
		logic                         nz;
		logic [7:0]                   duty;
		logic [NBASE-1:0][31:0]       qf;
		logic [NBASE-1:0][7:0]        n;
	} srch_t;

	// Request travelling down the selection chain
	typedef struct packed {
		logic                         nz;
		logic [7:0]                   duty;
		logic [NBASE-1:0][39:0]       err_num;
		logic [NBASE-1:0][13:0]       err_den;
		logic [NBASE-1:0][7:0]        n;
		logic [39:0]                  best_num;
		logic [13:0]                  best_den;
		logic [7:0]                   best_n;
		logic [1:0]                   best_tb;
	} score_t;

endpackage

FILE: src/pds_cell.sv
`timescale 1ns / 1ps
module pds_cell #(
	parameter int BIT = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  pds_pkg::srch_t d,
	output logic          vld_out,
	output pds_pkg::srch_t q
);

	logic           vld_q;
	pds_pkg::srch_t data_q;
	pds_pkg::srch_t nxt;
	logic [7:0]     t   [pds_pkg::NBASE];
	logic [8:0]     odd [pds_pkg::NBASE];
	logic [40:0]    prod[pds_pkg::NBASE];

	// Try this bit of each period count: keep it while 2P >= (2t-1)*Q*f
	always_comb begin
		nxt = d;
		for (int i = 0; i < pds_pkg::NBASE; i++) begin
			t[i]    = d.n[i] | (8'd1 << BIT);
			odd[i]  = {t[i], 1'b0} - 9'd1;
			prod[i] = {32'd0, odd[i]} * {9'd0, d.qf[i]};
			if ({14'd0, pds_pkg::BASE_P2[i]} >= prod[i]) begin
				nxt.n[i] = t[i];
			end
		end
	end

	// Advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign vld_out = vld_q;
	assign q       = data_q;

endmodule

FILE: src/pds_pick.sv
`timescale 1ns / 1ps
module pds_pick #(
	parameter int IDX = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  pds_pkg::score_t d,
	output logic            vld_out,
	output pds_pkg::score_t q
);

	logic            vld_q;
	pds_pkg::score_t data_q;
	pds_pkg::score_t nxt;
	logic [53:0]     lhs;
	logic [53:0]     rhs;

	// Take this base only on a strictly smaller error
	always_comb begin
		nxt = d;
		lhs = {14'd0, d.err_num[IDX]} * {40'd0, d.best_den};
		rhs = {14'd0, d.best_num} * {40'd0, d.err_den[IDX]};
		if (lhs < rhs) begin
			nxt.best_num = d.err_num[IDX];
			nxt.best_den = d.err_den[IDX];
			nxt.best_n   = d.n[IDX];
			nxt.best_tb  = 2'(IDX);
		end
	end

	// Advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign vld_out = vld_q;
	assign q       = data_q;

endmodule

FILE: src/pulser_divider_select.sv
`timescale 1ns / 1ps
// Pulse setting selector.
// A request is taken on a rising edge with start high and busy low; freq_hz
// and duty_percent are sampled there. busy stays low: a new request may
// follow in every cycle, one request per cycle sustained.
// The result appears on ok, period_count, width_count and time_base,
// marked by done for one cycle.
// The receiver cannot stall; results are never held back.
// The chain: one stage forms Q*f for each base, eight
// cells settle one bit of every period count each by compare against 2P,
// one stage forms the errors, three cells pick the best base in order,
// and three stages scale, divide and clamp the width.
// A zero frequency gives a result with ok and all counts zero.
// Reset clears every valid bit in the chain; requests in flight are lost
// and done stays low until a new request has passed through.
module pulser_divider_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [25:0] freq_hz,
	input  logic [7:0]  duty_percent,
	output logic        done,
	output logic        ok,
	output logic [7:0]  period_count,
	output logic [7:0]  width_count,
	output logic [1:0]  time_base
);

	localparam int NB = pds_pkg::NBASE;
	localparam int NC = pds_pkg::NBITS;

	logic             vld_s1;
	pds_pkg::srch_t   srch_s1;
	logic             cvld [NC+1];
	pds_pkg::srch_t   cdat [NC+1];
	logic             vld_s10;
	pds_pkg::score_t  sc_s10;
	pds_pkg::score_t  sc_nxt;
	logic             pvld [NB];
	pds_pkg::score_t  pdat [NB];
	logic             vld_s14, vld_s15;
	logic             nz_s14, nz_s15;
	logic [15:0]      wprod_s14, wprod_s15;
	logic [7:0]       n_s14, n_s15;
	logic [1:0]       tb_s14, tb_s15;
	logic [9:0]       quo_s15;
	logic [28:0]      recip;
	logic [16:0]      rem;
	logic [9:0]       quo;
	logic [9:0]       wfin;
	logic [7:0]       nmax;
	logic [7:0]       nclamp [NB];
	logic [39:0]      pn     [NB];
	logic [25:0]      ph     [NB];
	logic             done_q;
	logic             ok_q;
	logic [7:0]       period_q, width_q;
	logic [1:0]       tb_q;

	assign busy = 1'b0;

	// Form Q*f for every base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		srch_s1.nz   <= (freq_hz != 26'd0);
		srch_s1.duty <= duty_percent;
		for (int i = 0; i < NB; i++) begin
			srch_s1.qf[i] <= 32'({26'd0, pds_pkg::BASE_Q[i]} * {6'd0, freq_hz});
			srch_s1.n[i]  <= 8'd0;
		end
	end

	// Search chain, most significant bit first
	assign cvld[0] = vld_s1;
	assign cdat[0] = srch_s1;

	for (genvar c = 0; c < NC; c++) begin : g_cell
		pds_cell #(.BIT(NC - 1 - c)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (cvld[c]),
			.d      (cdat[c]),
			.vld_out(cvld[c+1]),
			.q      (cdat[c+1])
		);
	end

	// Clamp counts and form errors; base 0 seeds the best
	always_comb begin
		sc_nxt.nz   = cdat[NC].nz;
		sc_nxt.duty = cdat[NC].duty;
		for (int i = 0; i < NB; i++) begin
			nclamp[i] = (cdat[NC].n[i] < pds_pkg::N_MIN) ? pds_pkg::N_MIN : cdat[NC].n[i];
			pn[i]     = 40'({32'd0, nclamp[i]} * {8'd0, cdat[NC].qf[i]});
			ph[i]     = pds_pkg::BASE_P2[i][26:1];
			sc_nxt.err_num[i] = (pn[i] > {14'd0, ph[i]}) ? (pn[i] - {14'd0, ph[i]})
			                                            : ({14'd0, ph[i]} - pn[i]);
			sc_nxt.err_den[i] = 14'({8'd0, pds_pkg::BASE_Q[i]} * {6'd0, nclamp[i]});
			sc_nxt.n[i]       = nclamp[i];
		end
		sc_nxt.best_num = sc_nxt.err_num[0];
		sc_nxt.best_den = sc_nxt.err_den[0];
		sc_nxt.best_n   = sc_nxt.n[0];
		sc_nxt.best_tb  = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= cvld[NC];
		end
	end

	always_ff @(posedge clk) begin
		sc_s10 <= sc_nxt;
	end

	// Selection chain over the remaining bases
	assign pvld[0] = vld_s10;
	assign pdat[0] = sc_s10;

	for (genvar k = 1; k < NB; k++) begin : g_pick
		pds_pick #(.IDX(k)) u_pick (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (pvld[k-1]),
			.d      (pdat[k-1]),
			.vld_out(pvld[k]),
			.q      (pdat[k])
		);
	end

	// Scale duty by the chosen period, then divide by a hundred
	assign recip = {13'd0, wprod_s14} * {16'd0, pds_pkg::PCT_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else begin
			vld_s14 <= pvld[NB-1];
			vld_s15 <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		nz_s14    <= pdat[NB-1].nz;
		n_s14     <= pdat[NB-1].best_n;
		tb_s14    <= pdat[NB-1].best_tb;
		wprod_s14 <= {8'd0, pdat[NB-1].duty} * {8'd0, pdat[NB-1].best_n};
		nz_s15    <= nz_s14;
		n_s15     <= n_s14;
		tb_s15    <= tb_s14;
		wprod_s15 <= wprod_s14;
		quo_s15   <= recip[28:19];
	end

	// Correct the quotient by one and clamp the width into 1..n-1
	always_comb begin
		rem  = {1'b0, wprod_s15} - 17'({7'd0, quo_s15} * {10'd0, pds_pkg::PCT});
		quo  = (rem >= {10'd0, pds_pkg::PCT}) ? quo_s15 + 10'd1 : quo_s15;
		nmax = n_s15 - 8'd1;
		wfin = quo;
		if (wfin > {2'd0, nmax}) begin
			wfin = {2'd0, nmax};
		end
		if (wfin < {2'd0, pds_pkg::W_MIN}) begin
			wfin = {2'd0, pds_pkg::W_MIN};
		end
	end

	// Drive the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		ok_q     <= nz_s15;
		period_q <= nz_s15 ? n_s15 : 8'd0;
		width_q  <= nz_s15 ? wfin[7:0] : 8'd0;
		tb_q     <= nz_s15 ? tb_s15 : 2'd0;
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign period_count = period_q;
	assign width_count  = width_q;
	assign time_base    = tb_q;

	// A result follows its request by the full chain length
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 16))
		else $error("result without matching request");

	// A valid result keeps the counts in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok) |-> (period_count >= 8'd2 && width_count >= 8'd1
		                  && width_count < period_count))
		else $error("counts out of range");

	// An invalid request gives all zeros
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (period_count == 8'd0 && width_count == 8'd0
		                   && time_base == 2'd0))
		else $error("non-zero result for zero frequency");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [25:0] freq_hz;
	logic [7:0]  duty_percent;
	logic        done;
	logic        ok;
	logic [7:0]  period_count;
	logic [7:0]  width_count;
	logic [1:0]  time_base;

	typedef struct packed {
		logic       ok;
		logic [7:0] period;
		logic [7:0] width;
		logic [1:0] tb;
	} setting_t;

	// directed row: request plus optional typed-in setting
	typedef struct {
		logic [25:0] freq;
		logic [7:0]  duty;
		bit          fixed;
		setting_t    want;
	} row_t;

	setting_t settings_due[$];
	int       errors;
	int       n_requests;
	int       n_settings;
	int       tb_seen[4];

	pulser_divider_select i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.freq_hz      (freq_hz),
		.duty_percent (duty_percent),
		.done         (done),
		.ok           (ok),
		.period_count (period_count),
		.width_count  (width_count),
		.time_base    (time_base)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// pick base and counts for a wanted frequency and duty
	function automatic setting_t pick_setting(logic [25:0] f, logic [7:0] d);
		longint unsigned num[4];
		longint unsigned den[4];
		longint unsigned qf, n, prod, en, ed, bn, bd, w;
		setting_t s;
		num = '{40000000, 625000, 100000, 125};
		den = '{1, 1, 41, 13};
		s = '0;
		bn = 0;
		bd = 1;
		if (f == 0)
			return s;
		s.ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			qf = den[i] * f;
			n = (2 * num[i] + qf) / (2 * qf);
			if (n > 255) n = 255;
			if (n < 2) n = 2;
			prod = den[i] * n * f;
			en = (prod > num[i]) ? prod - num[i] : num[i] - prod;
			ed = den[i] * n;
			if (i == 0 || en * bd < bn * ed) begin
				bn = en;
				bd = ed;
				w = (d * n) / 100;
				if (w > n - 1) w = n - 1;
				if (w < 1) w = 1;
				s.period = n[7:0];
				s.width = w[7:0];
				s.tb = i[1:0];
			end
		end
		return s;
	endfunction

	// issue one request, holding start until accepted, with a random gap before
	task automatic send_request(logic [25:0] f, logic [7:0] d, setting_t want);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		freq_hz <= f;
		duty_percent <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		settings_due.push_back(want);
		n_requests++;
	endtask

	// compare each strobed setting with the oldest pending one
	always @(posedge clk) begin
		setting_t got, exp_s;
		if (arst_n && done) begin
			got = '{ok, period_count, width_count, time_base};
			if (settings_due.size() == 0) begin
				$display("%0t: unexpected setting %h", $time, got);
				errors++;
			end else begin
				exp_s = settings_due.pop_front();
				n_settings++;
				tb_seen[time_base]++;
				if (got.ok !== exp_s.ok) begin
					$display("%0t: ok exp %0d got %0d", $time, exp_s.ok, got.ok);
					errors++;
				end
				if (got.period !== exp_s.period) begin
					$display("%0t: period exp %0d got %0d", $time, exp_s.period, got.period);
					errors++;
				end
				if (got.width !== exp_s.width) begin
					$display("%0t: width exp %0d got %0d", $time, exp_s.width, got.width);
					errors++;
				end
				if (got.tb !== exp_s.tb) begin
					$display("%0t: base exp %0d got %0d", $time, exp_s.tb, got.tb);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t rows[$];
		logic [25:0] f;
		logic [7:0]  d;
		int sel, waited;
		errors = 0;
		n_requests = 0;
		n_settings = 0;
		tb_seen = '{0, 0, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		freq_hz = '0;
		duty_percent = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero frequency, extremes of both fields, ties and clamps
		rows.push_back('{26'd0, 8'd50, 1, '{1'b0, 8'd0, 8'd0, 2'd0}});
		rows.push_back('{26'd0, 8'd255, 1, '{1'b0, 8'd0, 8'd0, 2'd0}});
		rows.push_back('{26'h3FFFFFF, 8'd50, 1, '{1'b1, 8'd2, 8'd1, 2'd0}});
		rows.push_back('{26'h3FFFFFF, 8'd255, 1, '{1'b1, 8'd2, 8'd1, 2'd0}});
		rows.push_back('{26'h3FFFFFF, 8'd0, 1, '{1'b1, 8'd2, 8'd1, 2'd0}});
		rows.push_back('{26'd20000000, 8'd50, 1, '{1'b1, 8'd2, 8'd1, 2'd0}});
		rows.push_back('{26'd1, 8'd50, 0, '0});
		rows.push_back('{26'd1, 8'd0, 0, '0});
		rows.push_back('{26'd1, 8'd255, 0, '0});
		rows.push_back('{26'd10, 8'd100, 0, '0});
		rows.push_back('{26'd156862, 8'd50, 0, '0});
		rows.push_back('{26'd156863, 8'd50, 0, '0});
		rows.push_back('{26'd2451, 8'd33, 0, '0});
		rows.push_back('{26'd3000, 8'd1, 0, '0});
		rows.push_back('{26'd25, 8'd99, 0, '0});
		rows.push_back('{26'd5, 8'd200, 0, '0});
		rows.push_back('{26'd100000, 8'd10, 0, '0});
		rows.push_back('{26'd1000000, 8'd75, 0, '0});
		rows.push_back('{26'h2AAAAAA, 8'hAA, 0, '0});
		rows.push_back('{26'h1555555, 8'h55, 0, '0});
		foreach (rows[i])
			send_request(rows[i].freq, rows[i].duty,
				rows[i].fixed ? rows[i].want : pick_setting(rows[i].freq, rows[i].duty));

		// random requests, mostly in the range where the bases compete
		for (int k = 0; k < 1330; k++) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: f = 26'($urandom);
				1: f = 26'($urandom_range(0, 3));
				2, 3: f = 26'($urandom_range(1, 50));
				4, 5: f = 26'($urandom_range(1, 10000));
				6, 7: f = 26'($urandom_range(1, 400000));
				default: f = 26'($urandom_range(1, 25000000));
			endcase
			d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
			send_request(f, d, pick_setting(f, d));
		end
		start <= 1'b0;

		// drain, then let the chain settle
		waited = 0;
		while (settings_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (settings_due.size() != 0) begin
			$display("%0t: %0d settings never arrived", $time, settings_due.size());
			errors++;
		end
		$display("Sent %0d requests, checked %0d settings", n_requests, n_settings);
		$display("Bases chosen: 25ns %0d, 1600ns %0d, 410us %0d, 104ms %0d",
			tb_seen[0], tb_seen[1], tb_seen[2], tb_seen[3]);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
src/pds_pkg.sv
src/pds_cell.sv
src/pds_pick.sv
src/pulser_divider_select.sv
tb/testbench.sv
